@@ rtl/phic_pkg.sv @@
package phic_pkg;

	// Result event codes
	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_START     = 3'd1,
		EV_LOW_WATER = 3'd2,
		EV_MAX_TIME  = 3'd3,
		EV_MOISTURE  = 3'd4
	} event_t;

	// Configuration register indexes
	localparam logic [2:0] REG_SOIL_START  = 3'd0;
	localparam logic [2:0] REG_SOIL_STOP   = 3'd1;
	localparam logic [2:0] REG_WATER_MIN   = 3'd2;
	localparam logic [2:0] REG_MIN_RUN     = 3'd3;
	localparam logic [2:0] REG_MAX_RUN     = 3'd4;
	localparam logic [2:0] REG_MIN_REST    = 3'd5;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	// Field widths
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SOIL_W  = 7;
	localparam int unsigned WATER_W = 12;

	// Register values after reset
	localparam logic [SOIL_W-1:0]  SOIL_START_RST = 7'd10;
	localparam logic [SOIL_W-1:0]  SOIL_STOP_RST  = 7'd20;
	localparam logic [WATER_W-1:0] WATER_MIN_RST  = 12'd1000;
	localparam logic [TIME_W-1:0]  MIN_RUN_RST    = 32'd30000;
	localparam logic [TIME_W-1:0]  MAX_RUN_RST    = 32'd120000;
	localparam logic [TIME_W-1:0]  MIN_REST_RST   = 32'd30000;

endpackage

@@ rtl/phic_tick_if.sv @@
interface phic_tick_if;
	logic                             valid;
	logic                             ready;
	logic [phic_pkg::TIME_W-1:0]      now_ms;
	logic [phic_pkg::SOIL_W-1:0]      soil_moisture;
	logic [phic_pkg::WATER_W-1:0]     water_level;

	modport source (output valid, output now_ms, output soil_moisture,
		output water_level, input ready);
	modport sink (input valid, input now_ms, input soil_moisture,
		input water_level, output ready);
endinterface

@@ rtl/phic_result_if.sv @@
interface phic_result_if;
	logic                valid;
	logic                ready;
	logic                pump_on;
	logic [2:0]          event_code;

	modport source (output valid, output pump_on, output event_code, input ready);
	modport sink (input valid, input pump_on, input event_code, output ready);
endinterface

@@ rtl/pump_hysteresis_interlock_controller.sv @@
// Pump on/off controller with hysteresis and minimum run, maximum run and
// minimum rest times. Each control tick transferred on the tick channel gives
// exactly one result (relay drive and event code): the transfer edge loads the
// input register, and the result register loads from it once it is free; the
// state (running flag, start and stop stamps) is updated with that load. A new
// tick is taken on every cycle as long as the result channel keeps up; a
// stalled result holds the result register, and the input register too once
// it is full. Elapsed times are now_ms minus a stamp, modulo 2^32.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata and must only change while no tick is in flight; indexes above
// five are ignored. After reset the stop stamp is zero, so the first start
// waits until now_ms reaches min_rest_ms.
module pump_hysteresis_interlock_controller (
	input  logic                                   clk,
	input  logic                                   arst_n,
	phic_tick_if.sink                              tick,
	phic_result_if.source                          result,
	input  logic                                   cfg_wr_en,
	input  logic [phic_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [phic_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	logic [phic_pkg::SOIL_W-1:0]  soil_start_q;
	logic [phic_pkg::SOIL_W-1:0]  soil_stop_q;
	logic [phic_pkg::WATER_W-1:0] water_min_q;
	logic [phic_pkg::TIME_W-1:0]  min_run_q;
	logic [phic_pkg::TIME_W-1:0]  max_run_q;
	logic [phic_pkg::TIME_W-1:0]  min_rest_q;

	logic                         running_q;
	logic [phic_pkg::TIME_W-1:0]  start_stamp_q;
	logic [phic_pkg::TIME_W-1:0]  stop_stamp_q;

	logic                         v_s1;
	logic [phic_pkg::TIME_W-1:0]  now_s1;
	logic [phic_pkg::SOIL_W-1:0]  soil_s1;
	logic [phic_pkg::WATER_W-1:0] water_s1;

	logic                         v_s2;
	logic                         pump_on_s2;
	phic_pkg::event_t             event_s2;

	logic                         adv_s2;
	logic                         load_s2;
	logic                         take_s1;
	logic [phic_pkg::TIME_W-1:0]  ran_ms;
	logic [phic_pkg::TIME_W-1:0]  rest_ms;
	logic                         water_ok;
	logic                         running_nx;
	phic_pkg::event_t             event_nx;

	// Handshake: result register frees when empty or taken
	assign adv_s2     = !v_s2 || result.ready;
	assign load_s2    = v_s1 && adv_s2;
	assign tick.ready = !v_s1 || adv_s2;
	assign take_s1    = tick.valid && tick.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soil_start_q <= phic_pkg::SOIL_START_RST;
			soil_stop_q  <= phic_pkg::SOIL_STOP_RST;
			water_min_q  <= phic_pkg::WATER_MIN_RST;
			min_run_q    <= phic_pkg::MIN_RUN_RST;
			max_run_q    <= phic_pkg::MAX_RUN_RST;
			min_rest_q   <= phic_pkg::MIN_REST_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				phic_pkg::REG_SOIL_START: soil_start_q <= cfg_wdata[phic_pkg::SOIL_W-1:0];
				phic_pkg::REG_SOIL_STOP:  soil_stop_q  <= cfg_wdata[phic_pkg::SOIL_W-1:0];
				phic_pkg::REG_WATER_MIN:  water_min_q  <= cfg_wdata[phic_pkg::WATER_W-1:0];
				phic_pkg::REG_MIN_RUN:    min_run_q    <= cfg_wdata[phic_pkg::TIME_W-1:0];
				phic_pkg::REG_MAX_RUN:    max_run_q    <= cfg_wdata[phic_pkg::TIME_W-1:0];
				phic_pkg::REG_MIN_REST:   min_rest_q   <= cfg_wdata[phic_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tick.ready) begin
			v_s1 <= tick.valid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (take_s1) begin
			now_s1   <= tick.now_ms;
			soil_s1  <= tick.soil_moisture;
			water_s1 <= tick.water_level;
		end
	end

	// Decide start or stop for the registered tick
	assign ran_ms   = now_s1 - start_stamp_q;
	assign rest_ms  = now_s1 - stop_stamp_q;
	assign water_ok = water_s1 >= water_min_q;

	always_comb begin
		running_nx = running_q;
		event_nx   = phic_pkg::EV_NONE;
		if (!running_q) begin
			if (water_ok && rest_ms >= min_rest_q && soil_s1 < soil_start_q) begin
				running_nx = 1'b1;
				event_nx   = phic_pkg::EV_START;
			end
		end else if (!water_ok) begin
			running_nx = 1'b0;
			event_nx   = phic_pkg::EV_LOW_WATER;
		end else if (ran_ms >= max_run_q) begin
			running_nx = 1'b0;
			event_nx   = phic_pkg::EV_MAX_TIME;
		end else if (soil_s1 >= soil_stop_q && ran_ms >= min_run_q) begin
			running_nx = 1'b0;
			event_nx   = phic_pkg::EV_MOISTURE;
		end
	end

	// Controller state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			start_stamp_q <= '0;
			stop_stamp_q  <= '0;
			v_s2          <= 1'b0;
		end else begin
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (load_s2) begin
				running_q <= running_nx;
				if (event_nx == phic_pkg::EV_START) begin
					start_stamp_q <= now_s1;
				end else if (event_nx != phic_pkg::EV_NONE) begin
					stop_stamp_q <= now_s1;
				end
			end
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			pump_on_s2 <= running_nx;
			event_s2   <= event_nx;
		end
	end

	assign result.valid      = v_s2;
	assign result.pump_on    = pump_on_s2;
	assign result.event_code = event_s2;

`ifndef NO_ASSERTIONS
	// A shown result always matches the current running flag
	a_pump_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (pump_on_s2 == running_q))
		else $error("result pump_on differs from running state");

	// A start turns the pump on, any stop turns it off
	a_start_on: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && event_s2 == phic_pkg::EV_START) |-> pump_on_s2)
		else $error("start event with pump off");

	a_stop_off: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (event_s2 == phic_pkg::EV_LOW_WATER || event_s2 == phic_pkg::EV_MAX_TIME
		|| event_s2 == phic_pkg::EV_MOISTURE)) |-> !pump_on_s2)
		else $error("stop event with pump on");

	// State moves only when a tick reaches the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s2 |=> ($stable(running_q) && $stable(start_stamp_q) && $stable(stop_stamp_q)))
		else $error("controller state changed without a tick");
`endif

endmodule

@@ bench/phic_relay_checker.sv @@
`timescale 1ns / 100ps

module phic_relay_checker
	import phic_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	phic_tick_if                   tick,
	phic_result_if                 result,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int                     mismatch_count,
	output int                     relay_pending,
	output int                     start_count,
	output int                     stop_count
);

	typedef struct packed {
		logic   pump_on;
		event_t ev;
	} relay_word_t;

	// Shadow copy of the control registers
	logic [SOIL_W-1:0]  soil_start_lvl;
	logic [SOIL_W-1:0]  soil_stop_lvl;
	logic [WATER_W-1:0] water_floor;
	logic [TIME_W-1:0]  run_min_ms;
	logic [TIME_W-1:0]  run_max_ms;
	logic [TIME_W-1:0]  rest_min_ms;

	// Shadow pump state
	logic               pumping;
	logic [TIME_W-1:0]  start_ms;
	logic [TIME_W-1:0]  stop_ms;

	relay_word_t        expected_relay_q[$];
	relay_word_t        oldest;
	relay_word_t        decided;
	logic [TIME_W-1:0]  ran_ms;
	logic [TIME_W-1:0]  rested_ms;
	logic               bad;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soil_start_lvl = SOIL_START_RST;
			soil_stop_lvl  = SOIL_STOP_RST;
			water_floor    = WATER_MIN_RST;
			run_min_ms     = MIN_RUN_RST;
			run_max_ms     = MAX_RUN_RST;
			rest_min_ms    = MIN_REST_RST;
			pumping        = 1'b0;
			start_ms       = '0;
			stop_ms        = '0;
			expected_relay_q.delete();
			mismatch_count <= 0;
			relay_pending  <= 0;
			start_count    <= 0;
			stop_count     <= 0;
		end else begin
			// Compare a result transfer against the oldest prediction
			if (result.valid && result.ready) begin
				if (expected_relay_q.size() == 0) begin
					$display("%0t: result with nothing outstanding: expected none, got pump_on=%0b event=%0d",
						$time, result.pump_on, result.event_code);
					mismatch_count <= mismatch_count + 1;
				end else begin
					oldest = expected_relay_q.pop_front();
					bad = 1'b0;
					if (result.pump_on !== oldest.pump_on) begin
						bad = 1'b1;
						$display("%0t: pump_on mismatch: expected %0b, actual %0b",
							$time, oldest.pump_on, result.pump_on);
					end
					if (result.event_code !== oldest.ev) begin
						bad = 1'b1;
						$display("%0t: event_code mismatch: expected %0d (%s), actual %0d",
							$time, oldest.ev, oldest.ev.name(), result.event_code);
					end
					if (bad)
						mismatch_count <= mismatch_count + 1;
				end
			end

			// Decide the relay for each tick transfer
			if (tick.valid && tick.ready) begin
				ran_ms    = tick.now_ms - start_ms;
				rested_ms = tick.now_ms - stop_ms;
				decided.ev = EV_NONE;
				if (!pumping) begin
					if (tick.water_level >= water_floor && rested_ms >= rest_min_ms &&
						tick.soil_moisture < soil_start_lvl) begin
						pumping    = 1'b1;
						start_ms   = tick.now_ms;
						decided.ev = EV_START;
					end
				end else begin
					if (tick.water_level < water_floor)
						decided.ev = EV_LOW_WATER;
					else if (ran_ms >= run_max_ms)
						decided.ev = EV_MAX_TIME;
					else if (tick.soil_moisture >= soil_stop_lvl && ran_ms >= run_min_ms)
						decided.ev = EV_MOISTURE;
					if (decided.ev != EV_NONE) begin
						pumping = 1'b0;
						stop_ms = tick.now_ms;
					end
				end
				decided.pump_on = pumping;
				expected_relay_q.push_back(decided);
				if (decided.ev == EV_START)
					start_count <= start_count + 1;
				else if (decided.ev != EV_NONE)
					stop_count <= stop_count + 1;
			end

			// Mirror register writes; spare indexes are dropped
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SOIL_START: soil_start_lvl = cfg_wdata[SOIL_W-1:0];
					REG_SOIL_STOP:  soil_stop_lvl  = cfg_wdata[SOIL_W-1:0];
					REG_WATER_MIN:  water_floor    = cfg_wdata[WATER_W-1:0];
					REG_MIN_RUN:    run_min_ms     = cfg_wdata[TIME_W-1:0];
					REG_MAX_RUN:    run_max_ms     = cfg_wdata[TIME_W-1:0];
					REG_MIN_REST:   rest_min_ms    = cfg_wdata[TIME_W-1:0];
					default: ;
				endcase
			end

			relay_pending <= expected_relay_q.size();
		end
	end

endmodule

@@ bench/pump_hysteresis_interlock_controller_tb.sv @@
`timescale 1ns / 100ps

module pump_hysteresis_interlock_controller_tb;
	import phic_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_TOGGLE,
		RX_HEAVY
	} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	int                     relay_errors;
	int                     relay_pending;
	int                     starts_seen;
	int                     stops_seen;

	// Stimulus bookkeeping
	logic [TIME_W-1:0]      clock_ms;
	logic [SOIL_W-1:0]      cur_soil_start;
	logic [SOIL_W-1:0]      cur_soil_stop;
	logic [WATER_W-1:0]     cur_water_min;
	int                     burst_left;
	int                     ticks_sent;
	int                     settings_loaded;

	rx_mode_t               rx_mode = RX_OPEN;
	int unsigned            rx_left = 0;

	phic_tick_if   tick_ch ();
	phic_result_if result_ch ();

	pump_hysteresis_interlock_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	phic_relay_checker relay_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick_ch),
		.result         (result_ch),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (relay_errors),
		.relay_pending  (relay_pending),
		.start_count    (starts_seen),
		.stop_count     (stops_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side stalls: switch between open, light, toggling and heavy backpressure
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(8, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   result_ch.ready <= 1'b1;
			RX_LIGHT:  result_ch.ready <= ($urandom_range(0, 3) != 0);
			RX_TOGGLE: result_ch.ready <= rx_left[1];
			default:   result_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Present one tick and hold it until the transfer
	task automatic send_tick(input logic [TIME_W-1:0] now, input logic [SOIL_W-1:0] soil,
		input logic [WATER_W-1:0] water);
		tick_ch.valid         <= 1'b1;
		tick_ch.now_ms        <= now;
		tick_ch.soil_moisture <= soil;
		tick_ch.water_level   <= water;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// Drop valid for the requested idle gap, with junk on the payload
	task automatic idle_gap(input int unsigned cycles);
		if (cycles > 0) begin
			tick_ch.valid         <= 1'b0;
			tick_ch.now_ms        <= $urandom;
			tick_ch.soil_moisture <= SOIL_W'($urandom);
			tick_ch.water_level   <= WATER_W'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Hold off until every tick has produced its result
	task automatic settle();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (relay_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Write every register, with junk above the narrow fields, plus one spare index
	task automatic load_settings(input logic [SOIL_W-1:0] s_start, input logic [SOIL_W-1:0] s_stop,
		input logic [WATER_W-1:0] w_min, input logic [TIME_W-1:0] run_min,
		input logic [TIME_W-1:0] run_max, input logic [TIME_W-1:0] rest_min);
		logic [CFG_DATA_W-1:0] pad;
		pad = $urandom;
		put_reg(REG_SOIL_START, {pad[CFG_DATA_W-1:SOIL_W], s_start});
		pad = $urandom;
		put_reg(REG_SOIL_STOP, {pad[CFG_DATA_W-1:SOIL_W], s_stop});
		pad = $urandom;
		put_reg(REG_WATER_MIN, {pad[CFG_DATA_W-1:WATER_W], w_min});
		put_reg(REG_MIN_RUN, run_min);
		put_reg(REG_MAX_RUN, run_max);
		put_reg(REG_MIN_REST, rest_min);
		put_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
		cfg_wr_en <= 1'b0;
		cur_soil_start = s_start;
		cur_soil_stop  = s_stop;
		cur_water_min  = w_min;
		settings_loaded++;
	endtask

	function automatic logic [TIME_W-1:0] rand_span();
		return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 150);
	endfunction

	// Mostly a forward-running clock with readings near the thresholds,
	// some jumps back, wraps and pure noise
	task automatic send_random(input int count, input int unsigned step_max);
		logic [SOIL_W-1:0]  soil;
		logic [WATER_W-1:0] water;
		int unsigned        pick;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				idle_gap($urandom_range(0, 6));
				burst_left = $urandom_range(1, 24);
			end
			case ($urandom_range(0, 5))
				0:       soil = cur_soil_start - 1'b1;
				1:       soil = cur_soil_start;
				2:       soil = cur_soil_stop - 1'b1;
				3:       soil = cur_soil_stop;
				4:       soil = SOIL_W'($urandom_range(0, 100));
				default: soil = SOIL_W'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0:       water = cur_water_min - 1'b1;
				1:       water = cur_water_min;
				2:       water = WATER_W'($urandom);
				default: water = WATER_W'($urandom_range(cur_water_min, 4095));
			endcase
			pick = $urandom_range(0, 19);
			case (pick)
				0: begin
					clock_ms = $urandom;
					soil     = SOIL_W'($urandom);
					water    = WATER_W'($urandom);
				end
				1:       clock_ms = clock_ms - $urandom_range(1, 50);
				2:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 60);
				default: clock_ms = clock_ms + $urandom_range(0, step_max);
			endcase
			send_tick(clock_ms, soil, water);
			burst_left--;
		end
	endtask

	task automatic run_phase(input int count, input int unsigned step_max);
		send_random(count, step_max);
		settle();
	endtask

	initial begin
		#2_000_000;
		$display("timeout with %0d results still outstanding", relay_pending);
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		tick_ch.valid         = 1'b0;
		tick_ch.now_ms        = '0;
		tick_ch.soil_moisture = '0;
		tick_ch.water_level   = '0;
		result_ch.ready       = 1'b0;
		clock_ms              = '0;
		cur_soil_start        = SOIL_START_RST;
		cur_soil_stop         = SOIL_STOP_RST;
		cur_water_min         = WATER_MIN_RST;
		burst_left            = 0;
		ticks_sent            = 0;
		settings_loaded       = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks on the reset settings
		send_tick(32'd0, 7'd0, 12'd4095);          // rest counted from time zero
		send_tick(32'd29999, 7'd0, 12'd4095);
		send_tick(32'd30000, 7'd0, 12'd4095);      // start
		send_tick(32'd30001, 7'd127, 12'd4095);    // too early for a moisture stop
		send_tick(32'd60000, 7'd20, 12'd4095);     // moisture stop
		send_tick(32'd60001, 7'd0, 12'd4095);      // still resting
		send_tick(32'd90001, 7'd9, 12'd1000);      // start at the water floor
		send_tick(32'd90002, 7'd0, 12'd999);       // low-water stop
		send_tick(32'd120001, 7'd0, 12'd0);
		send_tick(32'd120002, 7'd0, 12'd4095);     // start
		send_tick(32'd240001, 7'd19, 12'd4095);
		send_tick(32'd240002, 7'd19, 12'd4095);    // max-time stop
		send_tick(32'd270002, 7'd10, 12'd4095);    // moisture not below start level
		send_tick(32'd5, 7'd0, 12'd4095);          // clock went back, reads as long rest
		send_tick(32'hFFFF_FFFF, 7'd127, 12'd0);   // low water beats max time
		send_tick(32'h7FFF_FFFF, 7'd0, 12'd4095);  // start
		send_tick(32'h7FFF_FFFE, 7'd0, 12'd4095);  // one step back wraps to max time
		settle();

		load_settings(7'd40, 7'd60, 12'd2048, 32'd20, 32'd120, 32'd30);
		run_phase(100, 12);
		load_settings(7'd0, 7'd0, 12'd0, 32'd0, 32'd0, 32'd0);
		run_phase(60, 5);
		load_settings(7'd127, 7'd127, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_phase(50, 12);
		load_settings(7'd100, 7'd0, 12'd0, 32'd0, 32'd0, 32'd0);
		run_phase(60, 5);
		load_settings(7'd90, 7'd25, 12'd300, 32'd0, 32'd60, 32'd0);
		run_phase(80, 8);
		load_settings(SOIL_START_RST, SOIL_STOP_RST, WATER_MIN_RST, MIN_RUN_RST, MAX_RUN_RST,
			MIN_REST_RST);
		run_phase(80, 9000);
		repeat (3) begin
			load_settings(SOIL_W'($urandom), SOIL_W'($urandom), WATER_W'($urandom),
				rand_span(), rand_span(), rand_span());
			run_phase(100, 10);
		end

		repeat (10) @(posedge clk);
		$display("sent %0d ticks over the reset settings and %0d written settings",
			ticks_sent, settings_loaded);
		$display("pump starts %0d, stops %0d, mismatches %0d", starts_seen, stops_seen, relay_errors);
		if (relay_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
